>>> design/rotary_encoder_button_qualifier_unit_defines.svh
// assertion macros for the rotary encoder and button qualifier
// included by the top level; no other dependencies
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_UNIT_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_UNIT_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define REBQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define REBQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define REBQ_ASSERT(lbl, prop, msg)
`define REBQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/rebq_pkg.sv
// shared types, constants and helpers for the encoder and button qualifier
// no dependencies
`default_nettype none
package rebq_pkg;

	localparam int RUN_W = 4;
	localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] PRESS_RST = 4'd2;
	localparam logic [CFG_DATA_W-1:0] RELEASE_RST = 4'd4;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_CW   = 2'd1,
		MODE_CCW  = 2'd2,
		MODE_BTN  = 2'd3
	} mode_t;

	typedef struct packed {
		logic cw_low;
		logic ccw_low;
		logic btn_low;
	} in_beat_t;

	typedef struct packed {
		logic ccw_step;
		logic cw_step;
		logic btn_press;
	} out_beat_t;

	// zero threshold behaves as one
	function automatic logic [RUN_W-1:0] thr_eff(input logic [CFG_DATA_W-1:0] r);
		return (r == '0) ? RUN_W'(1) : RUN_W'(r);
	endfunction

	// saturating run counter step, cleared when the line is not active
	function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run, input logic act);
		logic [RUN_W-1:0] nxt;
		nxt = '0;
		if (act) begin
			nxt = (run == RUN_MAX) ? RUN_MAX : run + RUN_W'(1);
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

>>> design/rotary_encoder_button_qualifier_unit.sv
// top level of the rotary encoder and push-button qualifier
// depends on rebq_pkg, rebq_core, rebq_out_reg and the assertion macro header
//
// Each input beat is one sample of the three active-low lines (clockwise pin,
// counter-clockwise pin, button); each beat yields exactly one output beat that
// flags at most one recognized event. In idle, per-line run counters count
// consecutive low samples; once one reaches press_samples the event is reported
// (counter-clockwise wins over clockwise, clockwise over button), the counters
// clear and the block holds until release_samples consecutive released samples
// are seen. A threshold of 0 acts as 1. The block takes one beat per clock:
// the state update is a single pass of logic on the accepted sample and the
// result lands in one output register, offered next cycle; input ready drops
// only while it is full and the consumer stalls. The user must write registers
// via cfg_we/cfg_idx/cfg_wdata with no beat in flight; the block does not check.
`default_nettype none
`include "rotary_encoder_button_qualifier_unit_defines.svh"
module rotary_encoder_button_qualifier_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output wire                            in_ready,
	input  rebq_pkg::in_beat_t             in_data,
	output wire                            out_valid,
	input  wire                            out_ready,
	output rebq_pkg::out_beat_t            out_data,
	input  wire                            cfg_we,
	input  wire [rebq_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [rebq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rebq_pkg::*;

	logic [CFG_DATA_W-1:0] press_q, release_q;
	logic                  in_accept;
	out_beat_t             evt;
	mode_t                 mode;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= PRESS_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PRESS:   press_q   <= cfg_wdata;
				CFG_RELEASE: release_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a sample beat is taken when the result register can hold its answer
	assign in_accept = in_valid && in_ready;

	rebq_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (in_accept),
		.smp         (in_data),
		.press_cfg   (press_q),
		.release_cfg (release_q),
		.evt         (evt),
		.mode        (mode)
	);

	rebq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.d         (evt),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// never more than one event per result beat
	`REBQ_ASSERT(a_one_event, out_valid |-> $onehot0(out_data), "more than one event flagged")
	// a sample taken in a held mode reports nothing
	`REBQ_ASSERT(a_held_quiet, (in_accept && mode != MODE_IDLE) |=> (out_data == '0), "event while held")
	// a reported event always moves the block into a held mode
	`REBQ_ASSERT(a_event_holds, (in_accept && evt != '0) |=> (mode != MODE_IDLE), "event without hold")
	// nothing is offered while in reset
	`REBQ_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid, "output valid during reset")

endmodule
`default_nettype wire

>>> design/rebq_core.sv
// run counters and mode state machine of the qualifier
// depends on rebq_pkg
`default_nettype none
module rebq_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            step_en,
	input  rebq_pkg::in_beat_t             smp,
	input  wire [rebq_pkg::CFG_DATA_W-1:0] press_cfg,
	input  wire [rebq_pkg::CFG_DATA_W-1:0] release_cfg,
	output rebq_pkg::out_beat_t            evt,
	output rebq_pkg::mode_t                mode
);
	import rebq_pkg::*;

	mode_t mode_q, mode_d;
	logic [RUN_W-1:0] cw_run_q, ccw_run_q, btn_run_q, rel_run_q;
	logic [RUN_W-1:0] cw_run_d, ccw_run_d, btn_run_d, rel_run_d;
	logic [RUN_W-1:0] press_thr, release_thr;
	logic released;

	assign press_thr   = thr_eff(press_cfg);
	assign release_thr = thr_eff(release_cfg);
	assign mode        = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			cw_run_q  <= '0;
			ccw_run_q <= '0;
			btn_run_q <= '0;
			rel_run_q <= '0;
		end else if (step_en) begin
			mode_q    <= mode_d;
			cw_run_q  <= cw_run_d;
			ccw_run_q <= ccw_run_d;
			btn_run_q <= btn_run_d;
			rel_run_q <= rel_run_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		cw_run_d  = cw_run_q;
		ccw_run_d = ccw_run_q;
		btn_run_d = btn_run_q;
		rel_run_d = rel_run_q;
		evt       = '0;
		released  = 1'b0;
		case (mode_q)
			MODE_IDLE: begin
				cw_run_d  = bump(cw_run_q, smp.cw_low);
				ccw_run_d = bump(ccw_run_q, smp.ccw_low);
				btn_run_d = bump(btn_run_q, smp.btn_low);
				if (ccw_run_d >= press_thr) begin
					mode_d = MODE_CCW;
					evt.ccw_step = 1'b1;
				end else if (cw_run_d >= press_thr) begin
					mode_d = MODE_CW;
					evt.cw_step = 1'b1;
				end else if (btn_run_d >= press_thr) begin
					mode_d = MODE_BTN;
					evt.btn_press = 1'b1;
				end
				if (mode_d != MODE_IDLE) begin
					cw_run_d  = '0;
					ccw_run_d = '0;
					btn_run_d = '0;
				end
			end
			MODE_CW, MODE_CCW, MODE_BTN: begin
				released  = (mode_q == MODE_BTN) ? !smp.btn_low
				                                 : (!smp.cw_low && !smp.ccw_low);
				rel_run_d = bump(rel_run_q, released);
				if (rel_run_d >= release_thr) begin
					mode_d    = MODE_IDLE;
					rel_run_d = '0;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/rebq_out_reg.sv
// result register with valid/ready handshake toward the consumer
// depends on rebq_pkg
`default_nettype none
module rebq_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  rebq_pkg::out_beat_t d,
	output wire                 can_load,
	output wire                 out_valid,
	input  wire                 out_ready,
	output rebq_pkg::out_beat_t out_data
);
	import rebq_pkg::*;

	logic      valid_s1;
	out_beat_t res_s1;

	// free slot, or the held beat leaves this cycle
	assign can_load  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= d;
		end
	end

endmodule
`default_nettype wire

>>> sim/tb_rotary_encoder_button_qualifier_unit.sv
// testbench for rotary_encoder_button_qualifier_unit: directed and random pin samples
// are checked beat by beat against a built-in model of the qualifier
// depends on rebq_pkg and the rotary_encoder_button_qualifier_unit rtl
`default_nettype none
module tb_rotary_encoder_button_qualifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rebq_pkg::*;

	// cycles with no accepted beat before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// long receiver hold-off used to fill the block and stall its input
	localparam int HOLD_CYCLES = 400;
	// extra cycles after the last expected beat
	localparam int DRAIN_SLACK = 3;
	// rough number of random samples per threshold setting
	localparam int BEATS_PER_SETTING = 145;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_PRESS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	rotary_encoder_button_qualifier_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// shared run state
	int error_count = 0;
	int idle_cycles = 0;
	int samples_sent = 0;
	bit idling = 1'b1;		// random gaps and stalls on both sides
	bit hold_req = 1'b0;	// asks the receiver for one long hold-off
	int stall_left = 0;

	// model of the qualifier: thresholds as written, mode and run counters
	logic [CFG_DATA_W-1:0] press_reg = PRESS_RST;
	logic [CFG_DATA_W-1:0] rel_reg = RELEASE_RST;
	mode_t pred_mode = MODE_IDLE;
	logic [RUN_W-1:0] cw_run = '0;
	logic [RUN_W-1:0] ccw_run = '0;
	logic [RUN_W-1:0] btn_run = '0;
	logic [RUN_W-1:0] rel_run = '0;

	// predicted event beats, oldest first
	out_beat_t expected_events[$];

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// saturating count of consecutive active samples, cleared when inactive
	function automatic logic [RUN_W-1:0] run_step(input logic [RUN_W-1:0] run, input logic act);
		if (!act)
			return '0;
		return (run == RUN_MAX) ? run : run + 1'b1;
	endfunction

	// advance the model by one sample and return the event it reports
	function automatic out_beat_t qualify_sample(input in_beat_t s);
		out_beat_t ev;
		logic [RUN_W-1:0] press_thr;
		logic [RUN_W-1:0] rel_thr;
		logic released;
		ev = '0;
		// a zero threshold counts as one
		press_thr = (press_reg == '0) ? RUN_W'(1) : press_reg;
		rel_thr = (rel_reg == '0) ? RUN_W'(1) : rel_reg;
		if (pred_mode == MODE_IDLE) begin
			cw_run = run_step(cw_run, s.cw_low);
			ccw_run = run_step(ccw_run, s.ccw_low);
			btn_run = run_step(btn_run, s.btn_low);
			// counter-clockwise beats clockwise, clockwise beats button
			if (ccw_run >= press_thr) begin
				pred_mode = MODE_CCW;
				ev.ccw_step = 1'b1;
			end else if (cw_run >= press_thr) begin
				pred_mode = MODE_CW;
				ev.cw_step = 1'b1;
			end else if (btn_run >= press_thr) begin
				pred_mode = MODE_BTN;
				ev.btn_press = 1'b1;
			end
			if (pred_mode != MODE_IDLE) begin
				cw_run = '0;
				ccw_run = '0;
				btn_run = '0;
			end
		end else begin
			// held rotary waits for both pins high, held button for the button high
			released = (pred_mode == MODE_BTN) ? !s.btn_low : !(s.cw_low || s.ccw_low);
			rel_run = run_step(rel_run, released);
			if (rel_run >= rel_thr) begin
				pred_mode = MODE_IDLE;
				rel_run = '0;
			end
		end
		return ev;
	endfunction

	function automatic in_beat_t mk_sample(input logic cw, input logic ccw, input logic btn);
		in_beat_t s;
		s.cw_low = cw;
		s.ccw_low = ccw;
		s.btn_low = btn;
		return s;
	endfunction

	// monitor: check the outgoing beat first, then predict for the incoming one;
	// one process keeps the order of queue pushes and pops fixed
	always @(posedge clk) begin
		out_beat_t exp_ev;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("result beat %b with nothing expected", out_data));
				end else begin
					exp_ev = expected_events.pop_front();
					if (out_data.ccw_step !== exp_ev.ccw_step)
						report_mismatch($sformatf("ccw_step got %b want %b",
							out_data.ccw_step, exp_ev.ccw_step));
					if (out_data.cw_step !== exp_ev.cw_step)
						report_mismatch($sformatf("cw_step got %b want %b",
							out_data.cw_step, exp_ev.cw_step));
					if (out_data.btn_press !== exp_ev.btn_press)
						report_mismatch($sformatf("btn_press got %b want %b",
							out_data.btn_press, exp_ev.btn_press));
				end
			end
			// register writes only happen while no beat is in flight
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PRESS: press_reg = cfg_wdata;
					CFG_RELEASE: rel_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_events.push_back(qualify_sample(in_data));
		end
	end

	// receiver: random one-cycle stalls, or one long counted hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			stall_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idling && ($urandom_range(99) < 25));
		end
	end

	// watchdog: ends the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_rotary_encoder_button_qualifier_unit: done, errors");
			$finish;
		end
	end

	// offer one sample, with an optional gap before it, and wait for acceptance;
	// valid is only lowered when a gap follows, so it never drops and rises in one step
	task automatic send_sample(input in_beat_t s);
		int gap;
		gap = 0;
		if (idling && ($urandom_range(99) < 25))
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
	endtask

	// stop offering and wait until every predicted beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_thresholds(input logic [CFG_DATA_W-1:0] press, input logic [CFG_DATA_W-1:0] rel);
		drain();
		write_reg(CFG_PRESS, press);
		write_reg(CFG_RELEASE, rel);
	endtask

	// one burst of pin activity: mostly clean steps and presses, some bounce and noise
	task automatic send_gesture();
		int kind;
		int n;
		int m;
		int i;
		logic b;
		kind = $urandom_range(9);
		// short runs mostly, now and then long enough to reach the counter limit
		n = ($urandom_range(7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
		m = ($urandom_range(7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
		b = ($urandom_range(5) == 0);
		case (kind)
			0, 1: begin
				// clockwise detent, button sometimes held along
				repeat (n) send_sample(mk_sample(1'b1, 1'b0, b));
				repeat (m) send_sample(mk_sample(1'b0, 1'b0, b));
			end
			2, 3: begin
				repeat (n) send_sample(mk_sample(1'b0, 1'b1, b));
				repeat (m) send_sample(mk_sample(1'b0, 1'b0, b));
			end
			4, 5: begin
				// button press with the encoder at rest
				repeat (n) send_sample(mk_sample(1'b0, 1'b0, 1'b1));
				repeat (m) send_sample(mk_sample(1'b0, 1'b0, 1'b0));
			end
			6: begin
				// quadrature sequence, overlap on both pins
				repeat (n) send_sample(mk_sample(1'b1, 1'b0, 1'b0));
				repeat (n) send_sample(mk_sample(1'b1, 1'b1, 1'b0));
				repeat (n) send_sample(mk_sample(1'b0, 1'b1, 1'b0));
				repeat (m) send_sample(mk_sample(1'b0, 1'b0, 1'b0));
			end
			7: begin
				// contact bounce on one line
				i = $urandom_range(2);
				repeat (n + m) begin
					b = 1'($urandom_range(1));
					send_sample(mk_sample(i == 0 ? b : 1'b0, i == 1 ? b : 1'b0, i == 2 ? b : 1'b0));
				end
			end
			default: begin
				repeat (n) send_sample(in_beat_t'(3'($urandom_range(7))));
			end
		endcase
	endtask

	// thresholds after reset: two lows for a step, four highs to release
	task automatic test_reset_thresholds();
		send_sample(mk_sample(1'b0, 1'b1, 1'b0));
		send_sample(mk_sample(1'b0, 1'b1, 1'b0));
		repeat (4) send_sample(mk_sample(1'b0, 1'b0, 1'b0));
	endtask

	// all lines low together, then clockwise with button, checking the ccw, cw, button order;
	// held button ignores the rotary pins and the idle counters stay cleared
	task automatic test_priority();
		apply_thresholds(4'd1, 4'd1);
		send_sample(mk_sample(1'b1, 1'b1, 1'b1));
		send_sample(mk_sample(1'b0, 1'b0, 1'b0));
		send_sample(mk_sample(1'b1, 1'b0, 1'b1));
		send_sample(mk_sample(1'b0, 1'b0, 1'b1));
		send_sample(mk_sample(1'b0, 1'b0, 1'b0));
		send_sample(mk_sample(1'b0, 1'b0, 1'b1));
		send_sample(mk_sample(1'b1, 1'b1, 1'b1));
		send_sample(mk_sample(1'b1, 1'b1, 1'b0));
	endtask

	// zero in both registers behaves as one
	task automatic test_zero_thresholds();
		apply_thresholds(4'd0, 4'd0);
		send_sample(mk_sample(1'b0, 1'b0, 1'b0));
		send_sample(mk_sample(1'b1, 1'b0, 1'b0));
		send_sample(mk_sample(1'b0, 1'b0, 1'b0));
	endtask

	// a run built up under a high threshold fires on the next low sample
	// once the threshold is lowered below it
	task automatic test_lowered_threshold();
		apply_thresholds(4'd15, 4'd15);
		repeat (5) send_sample(mk_sample(1'b1, 1'b0, 1'b0));
		apply_thresholds(4'd3, 4'd15);
		send_sample(mk_sample(1'b1, 1'b0, 1'b0));
		repeat (3) send_sample(mk_sample(1'b0, 1'b0, 1'b0));
		apply_thresholds(4'd3, 4'd1);
		send_sample(mk_sample(1'b0, 1'b0, 1'b0));
	endtask

	// random gestures under a spread of settings, extremes included;
	// one setting runs with no idling on either side
	task automatic test_random_gestures();
		logic [CFG_DATA_W-1:0] press_list[8];
		logic [CFG_DATA_W-1:0] rel_list[8];
		int k;
		int stop_at;
		press_list = '{4'd1, 4'd15, 4'd2, 4'd0, 4'd15, 4'd1, 4'd0, 4'd0};
		rel_list = '{4'd1, 4'd15, 4'd4, 4'd0, 4'd1, 4'd15, 4'd0, 4'd0};
		press_list[6] = CFG_DATA_W'($urandom_range(15));
		rel_list[6] = CFG_DATA_W'($urandom_range(15));
		press_list[7] = CFG_DATA_W'($urandom_range(15));
		rel_list[7] = CFG_DATA_W'($urandom_range(15));
		for (k = 0; k < 8; k++) begin
			apply_thresholds(press_list[k], rel_list[k]);
			idling = (k != 2);
			stop_at = samples_sent + BEATS_PER_SETTING;
			while (samples_sent < stop_at)
				send_gesture();
		end
		idling = 1'b1;
	endtask

	// long receiver hold-off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		apply_thresholds(4'd1, 4'd2);
		hold_req = 1'b1;
		repeat (40) send_sample(in_beat_t'(3'($urandom_range(7))));
		repeat (4) send_gesture();
	endtask

	initial begin
		// driven after every process is waiting, so the reset edge is seen
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_thresholds();
		test_priority();
		test_zero_thresholds();
		test_lowered_threshold();
		test_backpressure();
		test_random_gestures();
		drain();
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived", expected_events.size()));
		if (error_count == 0)
			$display("tb_rotary_encoder_button_qualifier_unit: done, clean");
		else
			$display("tb_rotary_encoder_button_qualifier_unit: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/rebq_pkg.sv
design/rebq_core.sv
design/rebq_out_reg.sv
design/rotary_encoder_button_qualifier_unit.sv
sim/tb_rotary_encoder_button_qualifier_unit.sv
